// ===== rtl/core/ffbt_pkg.sv =====
// shared types and codes of the first-fit block table
`timescale 1ns / 1ps

package ffbt_pkg;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO      = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BADHANDLE = 2'd3;

   // one result item
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  granted_handle;
      logic [31:0] granted_size;
      logic        reused;
   } rsp_type;

endpackage

// ===== rtl/core/ffbt_table.sv =====
// descriptor storage: size memory and free-mark memory, registered read
`timescale 1ns / 1ps

module ffbt_table import ffbt_pkg::*; #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 32,
   parameter int AW         = 6
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [SIZE_BITS-1:0] rd_size,
   output logic                 rd_mark,
   input  logic                 wr_size_en,
   input  logic                 wr_mark_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [SIZE_BITS-1:0] wr_size,
   input  logic                 wr_mark
);

   logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
   logic                 mark_mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic                 rd_mark_ff;

   always_ff @(posedge clock) begin
      if (wr_size_en) begin
         size_mem[wr_addr] <= wr_size;
      end
      if (wr_mark_en) begin
         mark_mem[wr_addr] <= wr_mark;
      end
      if (rd_en) begin
         rd_size_ff <= size_mem[rd_addr];
         rd_mark_ff <= mark_mem[rd_addr];
      end
   end

   assign rd_size = rd_size_ff;
   assign rd_mark = rd_mark_ff;

endmodule

// ===== rtl/core/ffbt_scan.sv =====
// command sequencer: free, first-fit scan over the table, append
`timescale 1ns / 1ps

module ffbt_scan import ffbt_pkg::*; #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 32,
   parameter int AW         = 6,
   parameter int CW         = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   input  logic [31:0]          req_size,
   input  logic [5:0]           req_handle,
   output logic                 busy,
   output logic                 done,
   output rsp_type              res,
   input  logic                 slot_free,
   output logic [CW-1:0]        entry_count,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  logic [SIZE_BITS-1:0] rd_size,
   input  logic                 rd_mark,
   output logic                 wr_size_en,
   output logic                 wr_mark_en,
   output logic [AW-1:0]        wr_addr,
   output logic [SIZE_BITS-1:0] wr_size,
   output logic                 wr_mark
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        iss_ff, iss_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic                 vld_ff, vld_in;
   logic [SIZE_BITS-1:0] req_ff, req_in;
   rsp_type              res_ff, res_in;
   logic [63:0]          req_wide;
   logic [SIZE_BITS-1:0] req_masked;
   logic [SIZE_BITS-1:0] app_size;
   logic                 do_append;

   function automatic logic [31:0] to_out(input logic [SIZE_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   assign req_wide   = 64'(req_size);
   assign req_masked = req_wide[SIZE_BITS-1:0];
   assign app_size   = (state_ff == S_IDLE) ? req_masked : req_ff;

   assign rd_en   = (state_ff == S_SCAN) && (iss_ff < count_ff);
   assign rd_addr = iss_ff[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      iss_in     = iss_ff;
      chk_in     = chk_ff;
      vld_in     = 1'b0;
      req_in     = req_ff;
      res_in     = res_ff;
      do_append  = 1'b0;
      wr_size_en = 1'b0;
      wr_mark_en = 1'b0;
      wr_addr    = '0;
      wr_size    = '0;
      wr_mark    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_command == CMD_FREE) begin
                  state_in = S_DONE;
                  if (32'(req_handle) >= 32'(count_ff)) begin
                     res_in.status = ST_BADHANDLE;
                  end else begin
                     wr_mark_en    = 1'b1;
                     wr_addr       = AW'(req_handle);
                     wr_mark       = 1'b1;
                     res_in.status = ST_OK;
                     // last entry leaves the table
                     if (32'(req_handle) + 32'd1 == 32'(count_ff)) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end else if (req_masked == '0) begin
                  res_in.status = ST_ZERO;
                  state_in      = S_DONE;
               end else if (count_ff == '0) begin
                  do_append = 1'b1;
               end else begin
                  req_in   = req_masked;
                  iss_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            vld_in = rd_en;
            chk_in = iss_ff[AW-1:0];
            if (vld_ff) begin
               if (rd_mark && (rd_size >= req_ff)) begin
                  wr_mark_en            = 1'b1;
                  wr_addr               = chk_ff;
                  wr_mark               = 1'b0;
                  res_in                = '0;
                  res_in.status         = ST_OK;
                  res_in.granted_handle = 6'(chk_ff);
                  res_in.granted_size   = to_out(rd_size);
                  res_in.reused         = 1'b1;
                  vld_in                = 1'b0;
                  state_in              = S_DONE;
               end else if (CW'(chk_ff) + CW'(1) == count_ff) begin
                  do_append = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_append) begin
         res_in   = '0;
         vld_in   = 1'b0;
         state_in = S_DONE;
         if (count_ff == CW'(MAX_BLOCKS)) begin
            res_in.status = ST_FULL;
         end else begin
            wr_size_en            = 1'b1;
            wr_mark_en            = 1'b1;
            wr_addr               = count_ff[AW-1:0];
            wr_size               = app_size;
            wr_mark               = 1'b0;
            count_in              = count_ff + CW'(1);
            res_in.status         = ST_OK;
            res_in.granted_handle = 6'(count_ff);
            res_in.granted_size   = to_out(app_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
         iss_ff   <= iss_in;
         chk_ff   <= chk_in;
         req_ff   <= req_in;
         res_ff   <= res_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign done        = (state_ff == S_DONE);
   assign res         = res_ff;
   assign entry_count = count_ff;

endmodule

// ===== rtl/core/first_fit_block_table.sv =====
// first-fit block table: top level with sequencer, descriptor memories and result register
// sequence: free, zero-size and empty-table allocate go from idle straight to done;
//   any other allocate walks the live entries to the first fit, else appends or is full
// flow: one item at a time, the next item is taken the cycle after the result is
//   registered, so an allocate holds the block for its whole first-fit memory walk
// reset: synchronous, empties the table (entry count to zero); memories need no clearing
`timescale 1ns / 1ps

module first_fit_block_table import ffbt_pkg::*; #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_size,
   input  logic [5:0]  req_handle,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_granted_handle,
   output logic [31:0] rsp_granted_size,
   output logic        rsp_reused
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   // sequencer to memory
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [SIZE_BITS-1:0] rd_size;
   logic                 rd_mark;
   logic                 wr_size_en;
   logic                 wr_mark_en;
   logic [AW-1:0]        wr_addr;
   logic [SIZE_BITS-1:0] wr_size;
   logic                 wr_mark;

   // sequencer to result register
   logic                 busy;
   logic                 done;
   rsp_type              res;
   logic                 slot_free;
   logic [CW-1:0]        entry_count;

   // result register
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // the output register can take a new item when empty or being drained
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // one item in flight: stall while the sequencer works or waits on the output
   assign req_stall = busy;

   ffbt_scan #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .AW         (AW),
      .CW         (CW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_size    (req_size),
      .req_handle  (req_handle),
      .busy        (busy),
      .done        (done),
      .res         (res),
      .slot_free   (slot_free),
      .entry_count (entry_count),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_size     (rd_size),
      .rd_mark     (rd_mark),
      .wr_size_en  (wr_size_en),
      .wr_mark_en  (wr_mark_en),
      .wr_addr     (wr_addr),
      .wr_size     (wr_size),
      .wr_mark     (wr_mark)
   );

   // size and free-mark storage, one entry per descriptor
   ffbt_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .AW         (AW)
   ) u_table (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_size    (rd_size),
      .rd_mark    (rd_mark),
      .wr_size_en (wr_size_en),
      .wr_mark_en (wr_mark_en),
      .wr_addr    (wr_addr),
      .wr_size    (wr_size),
      .wr_mark    (wr_mark)
   );

   // output register parts the sequencer from the response side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_granted_handle = rsp_ff.granted_handle;
   assign rsp_granted_size   = rsp_ff.granted_size;
   assign rsp_reused         = rsp_ff.reused;

   // live entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(entry_count) <= MAX_BLOCKS)
      else $error("entry count above table depth");

   // a failed item carries no grant
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_granted_handle == '0) && (rsp_granted_size == '0) && !rsp_reused)
      else $error("grant fields set on failed item");

   // an accepted item keeps the sequencer busy in the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

   // a reused grant points inside the table
   a_reuse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) && rsp_reused |->
         32'(rsp_granted_handle) < MAX_BLOCKS)
      else $error("reused handle outside table");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the first-fit block table: directed table, random traffic, self-checking
`timescale 1ns / 1ps

module tb_top;
   import ffbt_pkg::*;

   // table geometry of the block under test
   localparam int TABLE_DEPTH = 64;
   // run limit in clock cycles, far above the slowest correct run
   localparam int CYCLE_LIMIT = 1000000;
   // length of the long receiver hold-off, well past one full-table scan
   localparam int HOLD_CYCLES = 300;
   // settle time after the last result, one full scan plus margin
   localparam int TAIL_CYCLES = 80;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_ALLOC;
   logic [31:0] req_size = '0;
   logic [5:0]  req_handle = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_granted_handle;
   logic [31:0] rsp_granted_size;
   logic        rsp_reused;

   first_fit_block_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_size           (req_size),
      .req_handle         (req_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_granted_size   (rsp_granted_size),
      .rsp_reused         (rsp_reused)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shadow copy of the descriptor table, kept in step with accepted items
   logic [31:0] entry_size [TABLE_DEPTH];
   bit          entry_free [TABLE_DEPTH];
   int          live_count = 0;

   // results still owed by the block, oldest first
   rsp_type     pending_results [$];
   int          fail_count = 0;
   int          cycle_count = 0;

   // idle and stall rates in percent, set per phase
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   // hold-off request: the sender bumps hold_seq, the receiver side counts it out
   int          hold_seq = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   // one directed row: the item and, where obvious, its typed-in result
   typedef struct {
      logic        cmd;
      logic [31:0] size;
      logic [5:0]  handle;
      bit          fixed;
      rsp_type     want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;
   directed_row_type directed_rows [DIRECTED_ROWS];

   // apply one command to the shadow table and return the result it gives
   function automatic rsp_type apply_to_table(input logic cmd, input logic [31:0] size,
                                              input logic [5:0] handle);
      rsp_type r;
      int      i;
      r = '0;
      if (cmd == CMD_FREE) begin
         // only live entries can be freed; the last one drops out of the table
         if (int'(handle) >= live_count) begin
            r.status = ST_BADHANDLE;
         end else begin
            entry_free[handle] = 1'b1;
            if (int'(handle) + 1 == live_count) live_count--;
            r.status = ST_OK;
         end
         return r;
      end
      if (size == '0) begin
         r.status = ST_ZERO;
         return r;
      end
      // first fit: lowest free entry that is large enough, kept whole
      for (i = 0; i < live_count; i++) begin
         if (entry_free[i] && entry_size[i] >= size) begin
            entry_free[i]    = 1'b0;
            r.status         = ST_OK;
            r.granted_handle = i[5:0];
            r.granted_size   = entry_size[i];
            r.reused         = 1'b1;
            return r;
         end
      end
      if (live_count >= TABLE_DEPTH) begin
         r.status = ST_FULL;
         return r;
      end
      // no fit: append a new entry at the end of the table
      entry_size[live_count] = size;
      entry_free[live_count] = 1'b0;
      r.status         = ST_OK;
      r.granted_handle = live_count[5:0];
      r.granted_size   = size;
      live_count++;
      return r;
   endfunction

   // offer one item, hold it until taken, then record what it should give
   task automatic offer_item(input logic cmd, input logic [31:0] size,
                             input logic [5:0] handle, input bit fixed, input rsp_type want);
      rsp_type predicted;
      // random sender gaps ahead of the item
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_size    <= size;
      req_handle  <= handle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_to_table(cmd, size, handle);
      pending_results.push_back(fixed ? want : predicted);
   endtask

   // stop offering and wait until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // receiver: random stall, or a long hold-off when the sender asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result checker: every taken result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: status %0h", rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("granted_handle", 32'(want.granted_handle), 32'(rsp_granted_handle));
            check_field("granted_size", want.granted_size, rsp_granted_size);
            check_field("reused", 32'(want.reused), 32'(rsp_reused));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic        cmd;
      logic [31:0] size;
      logic [5:0]  handle;
      int          alloc_pct;
      int          pick;
      int          phase;
      int          n;
      int          k;

      // directed rows, starting from an empty table
      directed_rows = '{
         // free on an empty table: handle outside table
         '{CMD_FREE,  32'h0000_0000, 6'd0,  1'b1, '{ST_BADHANDLE, 6'd0, 32'd0, 1'b0}},
         // zero size, handle field at its top value
         '{CMD_ALLOC, 32'h0000_0000, 6'd63, 1'b1, '{ST_ZERO, 6'd0, 32'd0, 1'b0}},
         // largest size, then the smallest, both appended
         '{CMD_ALLOC, 32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'hFFFF_FFFF, 1'b0}},
         '{CMD_ALLOC, 32'h0000_0001, 6'd0,  1'b1, '{ST_OK, 6'd1, 32'd1, 1'b0}},
         '{CMD_ALLOC, 32'd100,       6'd0,  1'b0, '0},
         '{CMD_ALLOC, 32'h8000_0000, 6'd0,  1'b0, '0},
         // free in the middle leaves the entry in place
         '{CMD_FREE,  32'h0000_0000, 6'd1,  1'b1, '{ST_OK, 6'd0, 32'd0, 1'b0}},
         // exact fit takes the freed entry again
         '{CMD_ALLOC, 32'h0000_0001, 6'd0,  1'b0, '0},
         '{CMD_FREE,  32'hFFFF_FFFF, 6'd1,  1'b0, '0},
         // free entry too small: append instead
         '{CMD_ALLOC, 32'd50,        6'd0,  1'b0, '0},
         '{CMD_FREE,  32'h0000_0000, 6'd2,  1'b0, '0},
         // larger free entry taken whole, not split
         '{CMD_ALLOC, 32'd60,        6'd0,  1'b0, '0},
         // freeing the last entry shrinks the table, one entry at a time
         '{CMD_FREE,  32'h0000_0000, 6'd4,  1'b0, '0},
         '{CMD_FREE,  32'h0000_0000, 6'd3,  1'b0, '0},
         '{CMD_FREE,  32'h0000_0000, 6'd2,  1'b0, '0},
         // entry already free and last: removed
         '{CMD_FREE,  32'h0000_0000, 6'd1,  1'b0, '0},
         '{CMD_FREE,  32'h0000_0000, 6'd5,  1'b1, '{ST_BADHANDLE, 6'd0, 32'd0, 1'b0}},
         '{CMD_FREE,  32'h0000_0000, 6'd63, 1'b1, '{ST_BADHANDLE, 6'd0, 32'd0, 1'b0}},
         '{CMD_FREE,  32'h0000_0000, 6'd0,  1'b0, '0},
         // alternating bit patterns on the unused fields
         '{CMD_ALLOC, 32'h5555_AAAA, 6'd42, 1'b0, '0},
         '{CMD_FREE,  32'hAAAA_5555, 6'd0,  1'b0, '0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++) begin
         offer_item(directed_rows[k].cmd, directed_rows[k].size, directed_rows[k].handle,
                    directed_rows[k].fixed, directed_rows[k].want);
      end
      drain_results();

      // random traffic in four idling phases
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 81;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 81;
            end
            default: begin
               send_idle_pct = 34;
               stall_pct     = 34;
            end
         endcase
         alloc_pct = 60;
         for (n = 0; n < 158; n++) begin
            // allocate-heavy start fills the table; later stretches vary the mix
            if (phase == 0 && n < 80) begin
               alloc_pct = 95;
            end else if (n % 40 == 0) begin
               case ($urandom_range(2))
                  0: alloc_pct = 90;
                  1: alloc_pct = 60;
                  default: alloc_pct = 35;
               endcase
            end
            // long receiver hold-off while items keep coming
            if (phase == 0 && n == 100) hold_seq++;
            pick = $urandom_range(99);
            if ($urandom_range(99) < alloc_pct) begin
               cmd    = CMD_ALLOC;
               handle = 6'($urandom_range(63));
               // mostly small sizes so reuse hits often, some extremes and zero
               if (pick < 4)       size = '0;
               else if (pick < 6)  size = 32'hFFFF_FFFF;
               else if (pick < 70) size = $urandom_range(1, 64);
               else if (pick < 90) size = $urandom_range(1, 4096);
               else                size = $urandom;
            end else begin
               cmd  = CMD_FREE;
               size = $urandom;
               // mostly live handles, the last one often, some anywhere
               if (live_count > 0 && pick < 25) begin
                  handle = 6'(live_count - 1);
               end else if (live_count > 0 && pick < 80) begin
                  handle = 6'($urandom_range(live_count - 1));
               end else begin
                  handle = 6'($urandom_range(63));
               end
            end
            offer_item(cmd, size, handle, 1'b0, '0);
         end
         // sender pause until the block has answered everything
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
